[design/crsh_pkg.sv]
// Shared types, constants and helpers for the closest ray/sphere hit block.
// No dependencies; used by closest_ray_sphere_hit_top.
package crsh_pkg;

  localparam int MAX_SPHERES = 64;
  localparam int SLOT_W      = 6;
  localparam int CNT_W       = 7;
  localparam int MAT_W       = 8;
  localparam int NRM_W       = 18;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_TRACE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_COUNT = 2'd0,
    CFG_TMIN  = 2'd1,
    CFG_TMAX  = 2'd2
  } cfg_reg_e;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_MUL    = 13'b0000000000010,
    S_ACC    = 13'b0000000000100,
    S_FETCH  = 13'b0000000001000,
    S_OC     = 13'b0000000010000,
    S_SQRT   = 13'b0000000100000,
    S_ROOT   = 13'b0000001000000,
    S_DIV    = 13'b0000010000000,
    S_CHECK  = 13'b0000100000000,
    S_NEXT   = 13'b0001000000000,
    S_FFETCH = 13'b0010000000000,
    S_NORM   = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_e;

  typedef enum logic [3:0] {
    M_AA0 = 4'd0,
    M_AA1 = 4'd1,
    M_AA2 = 4'd2,
    M_B0  = 4'd3,
    M_B1  = 4'd4,
    M_B2  = 4'd5,
    M_C0  = 4'd6,
    M_C1  = 4'd7,
    M_C2  = 4'd8,
    M_C3  = 4'd9,
    M_BB  = 4'd10,
    M_AC  = 4'd11,
    M_P0  = 4'd12,
    M_P1  = 4'd13,
    M_P2  = 4'd14
  } mstep_e;

  typedef struct packed {
    logic [31:0]      cx;
    logic [31:0]      cy;
    logic [31:0]      cz;
    logic [30:0]      r;
    logic [MAT_W-1:0] mat;
  } sph_rec_t;

  // Clamp a signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > 64'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

[design/closest_ray_sphere_hit_top.sv]
// Closest-hit ray/sphere intersection over a 64-entry sphere memory.
// Depends on crsh_pkg (types, state codes, saturation helper).

// A load command (command_i low) writes one sphere into the memory in the cycle of its
// transfer; the block stays free. A trace command walks slots 0 up to min(sphere_count,
// 64)-1 through one shared 33x33 multiplier, a two-bit-per-cycle square root and a
// one-bit-per-cycle divider. Setup squares and sums the direction; each tested slot
// reads the memory, multiplies and accumulates, and advances, and when the discriminant
// is positive it takes a square root and one division per tried root (one or two). A
// hit adds the hit point and the three normal divisions, and a final state registers the
// result. The result appears on the output ports for exactly one cycle with done_o
// high; the receiver cannot stall it, so it must take it then. busy_o is high while a
// trace is in progress; a new command transfers at a rising edge with start_i high and
// busy_o low, which may be the cycle in which the previous result is shown. Configuration
// must be written through cfg_we_i, cfg_idx_i and cfg_data_i only while the block is
// idle; the block itself does not enforce this. Slots that were never loaded must not
// be traced.
module closest_ray_sphere_hit_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          command_i,
  input  logic [crsh_pkg::SLOT_W-1:0]   slot_i,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            pos_z_i,
  input  logic signed [31:0]            dir_x_i,
  input  logic signed [31:0]            dir_y_i,
  input  logic signed [31:0]            dir_z_i,
  input  logic [30:0]                   radius_i,
  input  logic [crsh_pkg::MAT_W-1:0]    material_id_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [30:0]                   cfg_data_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [30:0]                   distance_o,
  output logic signed [31:0]            point_x_o,
  output logic signed [31:0]            point_y_o,
  output logic signed [31:0]            point_z_o,
  output logic signed [crsh_pkg::NRM_W-1:0] normal_x_o,
  output logic signed [crsh_pkg::NRM_W-1:0] normal_y_o,
  output logic signed [crsh_pkg::NRM_W-1:0] normal_z_o,
  output logic [crsh_pkg::MAT_W-1:0]    hit_material_o,
  output logic [crsh_pkg::SLOT_W-1:0]   hit_slot_o
);

  // Configuration registers.
  logic [crsh_pkg::CNT_W-1:0] count_q;
  logic [30:0]                tmin_q, tmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tmin_q  <= 31'd66;
      tmax_q  <= 31'h7FFFFFFF;
    end else if (cfg_we_i) begin
      unique case (crsh_pkg::cfg_reg_e'(cfg_idx_i))
        crsh_pkg::CFG_COUNT: count_q <= cfg_data_i[crsh_pkg::CNT_W-1:0];
        crsh_pkg::CFG_TMIN:  tmin_q  <= cfg_data_i;
        crsh_pkg::CFG_TMAX:  tmax_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sphere memory: one write port for loads, one registered read port for traces.
  crsh_pkg::state_e  state_q;
  crsh_pkg::sph_rec_t mem [crsh_pkg::MAX_SPHERES];
  crsh_pkg::sph_rec_t rd_q;
  logic [crsh_pkg::SLOT_W-1:0] rd_addr;
  logic [crsh_pkg::CNT_W-1:0]  idx_q, n_q;
  logic [crsh_pkg::SLOT_W-1:0] best_q;
  logic fin_q;
  logic accept, mem_we;

  assign busy_o  = (state_q != crsh_pkg::S_IDLE);
  assign accept  = start_i && !busy_o;
  assign mem_we  = accept && (crsh_pkg::cmd_e'(command_i) == crsh_pkg::CMD_LOAD) &&
                   ({1'b0, slot_i} < crsh_pkg::CNT_W'(crsh_pkg::MAX_SPHERES));
  // During the hit tail the read port is parked on the winning slot.
  assign rd_addr = fin_q ? best_q : idx_q[crsh_pkg::SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot_i] <= '{cx: pos_x_i, cy: pos_y_i, cz: pos_z_i, r: radius_i,
                       mat: material_id_i};
    end
    rd_q <= mem[rd_addr];
  end

  // Datapath state.
  crsh_pkg::mstep_e step_q;
  logic signed [31:0] o_q [3];
  logic signed [31:0] d_q [3];
  logic signed [31:0] oc_q [3];
  logic signed [31:0] pt_q [3];
  logic signed [crsh_pkg::NRM_W-1:0] nrm_q [3];
  logic [30:0]        a_q, best_t_q;
  logic signed [31:0] b_q, c_q;
  logic [63:0]        bb_q;
  logic signed [65:0] prod_q;
  logic signed [49:0] acc_q;
  logic found_q, root_q;
  logic [1:0] j_q;
  logic [5:0] cnt_q;
  logic [63:0] rad_q;
  logic [34:0] srem_q;
  logic [31:0] sroot_q;
  logic [49:0] dq_q;
  logic [30:0] drem_q, den_q;
  logic        dneg_q;

  // Output registers.
  logic done_q, hit_q;
  logic [30:0] dist_q;
  logic signed [31:0] opt_q [3];
  logic signed [crsh_pkg::NRM_W-1:0] onrm_q [3];
  logic [crsh_pkg::MAT_W-1:0]  omat_q;
  logic [crsh_pkg::SLOT_W-1:0] oslot_q;

  // Shared multiplier operand selection.
  logic signed [32:0] m_a, m_b;
  always_comb begin
    unique case (step_q)
      crsh_pkg::M_AA0: begin m_a = {d_q[0][31], d_q[0]}; m_b = m_a; end
      crsh_pkg::M_AA1: begin m_a = {d_q[1][31], d_q[1]}; m_b = m_a; end
      crsh_pkg::M_AA2: begin m_a = {d_q[2][31], d_q[2]}; m_b = m_a; end
      crsh_pkg::M_B0:  begin m_a = {oc_q[0][31], oc_q[0]}; m_b = {d_q[0][31], d_q[0]}; end
      crsh_pkg::M_B1:  begin m_a = {oc_q[1][31], oc_q[1]}; m_b = {d_q[1][31], d_q[1]}; end
      crsh_pkg::M_B2:  begin m_a = {oc_q[2][31], oc_q[2]}; m_b = {d_q[2][31], d_q[2]}; end
      crsh_pkg::M_C0:  begin m_a = {oc_q[0][31], oc_q[0]}; m_b = m_a; end
      crsh_pkg::M_C1:  begin m_a = {oc_q[1][31], oc_q[1]}; m_b = m_a; end
      crsh_pkg::M_C2:  begin m_a = {oc_q[2][31], oc_q[2]}; m_b = m_a; end
      crsh_pkg::M_C3:  begin m_a = {2'b00, rd_q.r}; m_b = m_a; end
      crsh_pkg::M_BB:  begin m_a = {b_q[31], b_q}; m_b = m_a; end
      crsh_pkg::M_AC:  begin m_a = {2'b00, a_q}; m_b = {c_q[31], c_q}; end
      crsh_pkg::M_P0:  begin m_a = {2'b00, best_t_q}; m_b = {d_q[0][31], d_q[0]}; end
      crsh_pkg::M_P1:  begin m_a = {2'b00, best_t_q}; m_b = {d_q[1][31], d_q[1]}; end
      crsh_pkg::M_P2:  begin m_a = {2'b00, best_t_q}; m_b = {d_q[2][31], d_q[2]}; end
      default:         begin m_a = '0; m_b = '0; end
    endcase
  end

  // Combinational helpers around the registered product and the iterative units.
  logic signed [49:0] psh, acc_sum, acc_dif;
  logic signed [65:0] disc;
  logic [34:0] srem_sh, strial;
  logic [31:0] drem_sh;
  logic signed [50:0] t_val;
  logic signed [33:0] nb, num_root, num_norm, cen_j;
  logic signed [31:0] pt_j;
  logic [crsh_pkg::CNT_W-1:0] n_clamped;
  logic [1:0] p_idx;

  assign psh      = prod_q[65:16];
  assign acc_sum  = acc_q + psh;
  assign acc_dif  = acc_q - psh;
  assign disc     = $signed({2'b00, bb_q}) - prod_q;
  assign srem_sh  = {srem_q[32:0], rad_q[63:62]};
  assign strial   = {1'b0, sroot_q, 2'b01};
  assign drem_sh  = {drem_q, dq_q[49]};
  assign t_val    = dneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
  assign nb       = -$signed({{2{b_q[31]}}, b_q});
  assign num_root = root_q ? (nb + $signed({2'b00, sroot_q}))
                           : (nb - $signed({2'b00, sroot_q}));
  assign n_clamped = (count_q > crsh_pkg::CNT_W'(crsh_pkg::MAX_SPHERES))
                   ? crsh_pkg::CNT_W'(crsh_pkg::MAX_SPHERES) : count_q;
  assign p_idx    = 2'(step_q - crsh_pkg::M_P0);

  always_comb begin
    unique case (j_q)
      2'd0:    begin cen_j = {{2{rd_q.cx[31]}}, rd_q.cx}; pt_j = pt_q[0]; end
      2'd1:    begin cen_j = {{2{rd_q.cy[31]}}, rd_q.cy}; pt_j = pt_q[1]; end
      default: begin cen_j = {{2{rd_q.cz[31]}}, rd_q.cz}; pt_j = pt_q[2]; end
    endcase
  end
  assign num_norm = $signed({{2{pt_j[31]}}, pt_j}) - cen_j;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= crsh_pkg::S_IDLE;
      step_q   <= crsh_pkg::M_AA0;
      idx_q    <= '0;
      n_q      <= '0;
      best_q   <= '0;
      fin_q    <= 1'b0;
      found_q  <= 1'b0;
      root_q   <= 1'b0;
      j_q      <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      dist_q   <= '0;
      omat_q   <= '0;
      oslot_q  <= '0;
      a_q      <= '0;
      b_q      <= '0;
      c_q      <= '0;
      bb_q     <= '0;
      prod_q   <= '0;
      acc_q    <= '0;
      best_t_q <= '0;
      rad_q    <= '0;
      srem_q   <= '0;
      sroot_q  <= '0;
      dq_q     <= '0;
      drem_q   <= '0;
      den_q    <= '0;
      dneg_q   <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        o_q[k]    <= '0;
        d_q[k]    <= '0;
        oc_q[k]   <= '0;
        pt_q[k]   <= '0;
        nrm_q[k]  <= '0;
        opt_q[k]  <= '0;
        onrm_q[k] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        crsh_pkg::S_IDLE: begin
          if (accept && (crsh_pkg::cmd_e'(command_i) == crsh_pkg::CMD_TRACE)) begin
            o_q[0]  <= pos_x_i;
            o_q[1]  <= pos_y_i;
            o_q[2]  <= pos_z_i;
            d_q[0]  <= dir_x_i;
            d_q[1]  <= dir_y_i;
            d_q[2]  <= dir_z_i;
            acc_q   <= '0;
            found_q <= 1'b0;
            fin_q   <= 1'b0;
            idx_q   <= '0;
            step_q  <= crsh_pkg::M_AA0;
            state_q <= crsh_pkg::S_MUL;
          end
        end

        crsh_pkg::S_MUL: begin
          prod_q  <= m_a * m_b;
          state_q <= crsh_pkg::S_ACC;
        end

        crsh_pkg::S_ACC: begin
          state_q <= crsh_pkg::S_MUL;
          case (step_q)
            crsh_pkg::M_AA2: begin
              a_q      <= (acc_sum > 50'sd2147483647) ? 31'h7FFFFFFF : acc_sum[30:0];
              n_q      <= n_clamped;
              best_t_q <= tmax_q;
              // A zero-length direction or an empty table ends the trace as a miss.
              if (acc_sum == '0 || n_clamped == '0) begin
                state_q <= crsh_pkg::S_OUT;
              end else begin
                state_q <= crsh_pkg::S_FETCH;
              end
            end
            crsh_pkg::M_B2: begin
              b_q    <= crsh_pkg::sat32(64'(acc_sum));
              acc_q  <= '0;
              step_q <= crsh_pkg::M_C0;
            end
            crsh_pkg::M_C3: begin
              c_q    <= crsh_pkg::sat32(64'(acc_dif));
              step_q <= crsh_pkg::M_BB;
            end
            crsh_pkg::M_BB: begin
              bb_q   <= prod_q[63:0];
              step_q <= crsh_pkg::M_AC;
            end
            crsh_pkg::M_AC: begin
              // Tangent and missing rays have a discriminant at or below zero.
              if (disc <= 66'sd0) begin
                state_q <= crsh_pkg::S_NEXT;
              end else begin
                rad_q   <= disc[63:0];
                srem_q  <= '0;
                sroot_q <= '0;
                cnt_q   <= 6'd32;
                root_q  <= 1'b0;
                state_q <= crsh_pkg::S_SQRT;
              end
            end
            crsh_pkg::M_P0, crsh_pkg::M_P1, crsh_pkg::M_P2: begin
              pt_q[p_idx] <= crsh_pkg::sat32(64'(o_q[p_idx]) + 64'(psh));
              if (step_q == crsh_pkg::M_P2) begin
                j_q     <= '0;
                state_q <= crsh_pkg::S_NORM;
              end else begin
                step_q <= crsh_pkg::mstep_e'(step_q + 4'd1);
              end
            end
            default: begin
              acc_q  <= acc_sum;
              step_q <= crsh_pkg::mstep_e'(step_q + 4'd1);
            end
          endcase
        end

        crsh_pkg::S_FETCH: begin
          state_q <= crsh_pkg::S_OC;
        end

        crsh_pkg::S_OC: begin
          // A zero radius is never hit.
          if (rd_q.r == '0) begin
            state_q <= crsh_pkg::S_NEXT;
          end else begin
            oc_q[0] <= crsh_pkg::sat32(64'(o_q[0]) - 64'($signed(rd_q.cx)));
            oc_q[1] <= crsh_pkg::sat32(64'(o_q[1]) - 64'($signed(rd_q.cy)));
            oc_q[2] <= crsh_pkg::sat32(64'(o_q[2]) - 64'($signed(rd_q.cz)));
            acc_q   <= '0;
            step_q  <= crsh_pkg::M_B0;
            state_q <= crsh_pkg::S_MUL;
          end
        end

        crsh_pkg::S_SQRT: begin
          if (srem_sh >= strial) begin
            srem_q  <= srem_sh - strial;
            sroot_q <= {sroot_q[30:0], 1'b1};
          end else begin
            srem_q  <= srem_sh;
            sroot_q <= {sroot_q[30:0], 1'b0};
          end
          rad_q <= {rad_q[61:0], 2'b00};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            state_q <= crsh_pkg::S_ROOT;
          end
        end

        crsh_pkg::S_ROOT: begin
          dq_q    <= {(num_root < 0) ? 34'(-num_root) : 34'(num_root), 16'h0000};
          dneg_q  <= num_root < 0;
          drem_q  <= '0;
          den_q   <= a_q;
          cnt_q   <= 6'd50;
          state_q <= crsh_pkg::S_DIV;
        end

        crsh_pkg::S_NORM: begin
          dq_q    <= {(num_norm < 0) ? 34'(-num_norm) : 34'(num_norm), 16'h0000};
          dneg_q  <= num_norm < 0;
          drem_q  <= '0;
          den_q   <= rd_q.r;
          cnt_q   <= 6'd50;
          state_q <= crsh_pkg::S_DIV;
        end

        crsh_pkg::S_DIV: begin
          if (drem_sh >= {1'b0, den_q}) begin
            drem_q <= 31'(drem_sh - {1'b0, den_q});
            dq_q   <= {dq_q[48:0], 1'b1};
          end else begin
            drem_q <= drem_sh[30:0];
            dq_q   <= {dq_q[48:0], 1'b0};
          end
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            state_q <= crsh_pkg::S_CHECK;
          end
        end

        crsh_pkg::S_CHECK: begin
          if (fin_q) begin
            if (t_val > 51'sd65536) begin
              nrm_q[j_q] <= 18'sd65536;
            end else if (t_val < -51'sd65536) begin
              nrm_q[j_q] <= -18'sd65536;
            end else begin
              nrm_q[j_q] <= t_val[crsh_pkg::NRM_W-1:0];
            end
            if (j_q == 2'd2) begin
              state_q <= crsh_pkg::S_OUT;
            end else begin
              j_q     <= j_q + 2'd1;
              state_q <= crsh_pkg::S_NORM;
            end
          end else if (t_val < $signed({20'b0, best_t_q}) &&
                       t_val > $signed({20'b0, tmin_q})) begin
            best_t_q <= t_val[30:0];
            best_q   <= idx_q[crsh_pkg::SLOT_W-1:0];
            found_q  <= 1'b1;
            state_q  <= crsh_pkg::S_NEXT;
          end else if (!root_q) begin
            root_q  <= 1'b1;
            state_q <= crsh_pkg::S_ROOT;
          end else begin
            state_q <= crsh_pkg::S_NEXT;
          end
        end

        crsh_pkg::S_NEXT: begin
          if (idx_q + crsh_pkg::CNT_W'(1) >= n_q) begin
            if (found_q) begin
              fin_q   <= 1'b1;
              state_q <= crsh_pkg::S_FFETCH;
            end else begin
              state_q <= crsh_pkg::S_OUT;
            end
          end else begin
            idx_q   <= idx_q + crsh_pkg::CNT_W'(1);
            state_q <= crsh_pkg::S_FETCH;
          end
        end

        crsh_pkg::S_FFETCH: begin
          step_q  <= crsh_pkg::M_P0;
          state_q <= crsh_pkg::S_MUL;
        end

        crsh_pkg::S_OUT: begin
          done_q  <= 1'b1;
          hit_q   <= found_q;
          dist_q  <= found_q ? best_t_q : '0;
          omat_q  <= found_q ? rd_q.mat : '0;
          oslot_q <= found_q ? best_q : '0;
          for (int k = 0; k < 3; k++) begin
            opt_q[k]  <= found_q ? pt_q[k] : '0;
            onrm_q[k] <= found_q ? nrm_q[k] : '0;
          end
          state_q <= crsh_pkg::S_IDLE;
        end

        default: state_q <= crsh_pkg::S_IDLE;
      endcase
    end
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign distance_o     = dist_q;
  assign point_x_o      = opt_q[0];
  assign point_y_o      = opt_q[1];
  assign point_z_o      = opt_q[2];
  assign normal_x_o     = onrm_q[0];
  assign normal_y_o     = onrm_q[1];
  assign normal_z_o     = onrm_q[2];
  assign hit_material_o = omat_q;
  assign hit_slot_o     = oslot_q;

  // A result is shown only once the block is free again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");

  // One strobe per trace: the result strobe is never repeated back to back.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe repeated");

  // A miss reports zero distance and slot.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (distance_o == '0 && hit_slot_o == '0))
    else $error("miss carries nonzero fields");

  // A hit distance lies inside the configured bounds.
  a_hit_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (distance_o > tmin_q && distance_o < tmax_q))
    else $error("hit distance out of bounds");

endmodule

[tb/sv/closest_ray_sphere_hit_top_tb.sv]
// Self-checking testbench for closest_ray_sphere_hit_top: directed and random loads and traces.
// Depends on crsh_pkg and closest_ray_sphere_hit_top; needs no files or arguments.
module closest_ray_sphere_hit_top_tb;

  localparam longint ONE      = 65536;
  localparam int     PHASES   = 14;
  localparam int     PHASE_N  = 60;

  // One command as the sender drives it.
  typedef struct {
    crsh_pkg::cmd_e     cmd;
    logic [5:0]         slot;
    logic signed [31:0] pos [3];
    logic signed [31:0] dir [3];
    logic [30:0]        radius;
    logic [7:0]         mat;
  } ray_cmd_t;

  // One trace result as the block should present it.
  typedef struct {
    logic               hit;
    logic [30:0]        distance;
    logic signed [31:0] point [3];
    logic [17:0]        normal [3];
    logic [7:0]         mat;
    logic [5:0]         slot;
  } hit_rec_t;

  logic clk_i, rst_ni, start_i, busy_o, command_i;
  logic [5:0] slot_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i, dir_x_i, dir_y_i, dir_z_i;
  logic [30:0] radius_i;
  logic [7:0] material_id_i;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [30:0] cfg_data_i;
  logic done_o, hit_o;
  logic [30:0] distance_o;
  logic signed [31:0] point_x_o, point_y_o, point_z_o;
  logic signed [17:0] normal_x_o, normal_y_o, normal_z_o;
  logic [7:0] hit_material_o;
  logic [5:0] hit_slot_o;

  // Mirror of the sphere memory and of the configuration registers.
  logic signed [31:0] ctr_x [64];
  logic signed [31:0] ctr_y [64];
  logic signed [31:0] ctr_z [64];
  logic [30:0]        rad_mem [64];
  logic [7:0]         mat_mem [64];
  logic [6:0]         sphere_cnt;
  logic [30:0]        tmin_reg, tmax_reg;

  hit_rec_t pending_hits [$];
  int err_cnt;
  int burst_left;

  closest_ray_sphere_hit_top i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .slot_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .radius_i, .material_id_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_o, .hit_o, .distance_o, .point_x_o, .point_y_o, .point_z_o,
    .normal_x_o, .normal_y_o, .normal_z_o, .hit_material_o, .hit_slot_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #1000000000;
    $display("closest_ray_sphere_hit_top verification failed");
    $finish;
  end

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bit_v;
    res = 0;
    bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // Closest-hit search over the mirrored sphere memory. Shifts by 16 are
  // arithmetic (floor), divisions truncate toward zero.
  function automatic hit_rec_t closest_hit(input ray_cmd_t c);
    hit_rec_t h;
    longint o [3];
    longint d [3];
    longint oc [3];
    longint a, b, cq, r, disc, s, t, num, best_t, p, nrm, cen;
    int n, best;
    bit found;
    h = '{default: '0};
    for (int j = 0; j < 3; j++) begin
      o[j] = c.pos[j];
      d[j] = c.dir[j];
      h.point[j] = '0;
      h.normal[j] = '0;
    end
    found = 0;
    best = 0;
    a = 0;
    for (int j = 0; j < 3; j++) a += (d[j] * d[j]) >>> 16;
    a = clip(a, 0, 64'sd2147483647);
    if (a == 0) return h;
    n = sphere_cnt > 64 ? 64 : sphere_cnt;
    best_t = tmax_reg;
    for (int i = 0; i < n; i++) begin
      r = rad_mem[i];
      if (r == 0) continue;
      oc[0] = clip(o[0] - ctr_x[i], -64'sd2147483648, 64'sd2147483647);
      oc[1] = clip(o[1] - ctr_y[i], -64'sd2147483648, 64'sd2147483647);
      oc[2] = clip(o[2] - ctr_z[i], -64'sd2147483648, 64'sd2147483647);
      b = 0;
      cq = 0;
      for (int j = 0; j < 3; j++) begin
        b += (oc[j] * d[j]) >>> 16;
        cq += (oc[j] * oc[j]) >>> 16;
      end
      b = clip(b, -64'sd2147483648, 64'sd2147483647);
      cq = clip(cq - ((r * r) >>> 16), -64'sd2147483648, 64'sd2147483647);
      disc = b * b - a * cq;
      if (disc <= 0) continue;
      s = longint'(int_sqrt(disc));
      for (int root = 0; root < 2; root++) begin
        num = root == 0 ? (-b - s) : (-b + s);
        t = (num * ONE) / a;
        if (t < best_t && t > longint'(tmin_reg)) begin
          best_t = t;
          best = i;
          found = 1;
          break;
        end
      end
    end
    if (!found) return h;
    h.hit = 1'b1;
    h.distance = best_t[30:0];
    for (int j = 0; j < 3; j++) begin
      cen = j == 0 ? ctr_x[best] : (j == 1 ? ctr_y[best] : ctr_z[best]);
      p = clip(o[j] + ((best_t * d[j]) >>> 16), -64'sd2147483648, 64'sd2147483647);
      nrm = clip(((p - cen) * ONE) / longint'(rad_mem[best]), -ONE, ONE);
      h.point[j] = p[31:0];
      h.normal[j] = nrm[17:0];
    end
    h.mat = mat_mem[best];
    h.slot = best[5:0];
    return h;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  // Results are shown for exactly one cycle; sample in the middle of it.
  always @(negedge clk_i) begin
    hit_rec_t w;
    if (rst_ni && done_o) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("result with nothing pending", hit_o, 0);
      end else begin
        w = pending_hits.pop_front();
        if (hit_o !== w.hit) report_mismatch("hit", hit_o, w.hit);
        if (distance_o !== w.distance) report_mismatch("distance", distance_o, w.distance);
        if (point_x_o !== w.point[0]) report_mismatch("point_x", point_x_o, w.point[0]);
        if (point_y_o !== w.point[1]) report_mismatch("point_y", point_y_o, w.point[1]);
        if (point_z_o !== w.point[2]) report_mismatch("point_z", point_z_o, w.point[2]);
        if (normal_x_o !== w.normal[0])
          report_mismatch("normal_x", normal_x_o, $signed(w.normal[0]));
        if (normal_y_o !== w.normal[1])
          report_mismatch("normal_y", normal_y_o, $signed(w.normal[1]));
        if (normal_z_o !== w.normal[2])
          report_mismatch("normal_z", normal_z_o, $signed(w.normal[2]));
        if (hit_material_o !== w.mat) report_mismatch("hit_material", hit_material_o, w.mat);
        if (hit_slot_o !== w.slot) report_mismatch("hit_slot", hit_slot_o, w.slot);
      end
    end
  end

  // Sends one command. The sender works in bursts; between bursts start_i
  // may drop for a random gap. Acceptance is decided at the falling edge, where
  // busy_o is stable, and the transfer happens at the next rising edge.
  task automatic send_cmd(input ray_cmd_t c);
    int gap;
    bit took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i       <= 1'b1;
    command_i     <= c.cmd;
    slot_i        <= c.slot;
    pos_x_i       <= c.pos[0];
    pos_y_i       <= c.pos[1];
    pos_z_i       <= c.pos[2];
    dir_x_i       <= c.dir[0];
    dir_y_i       <= c.dir[1];
    dir_z_i       <= c.dir[2];
    radius_i      <= c.radius;
    material_id_i <= c.mat;
    do begin
      @(negedge clk_i);
      took = !busy_o;
      @(posedge clk_i);
    end while (!took);
    if (c.cmd == crsh_pkg::CMD_LOAD) begin
      ctr_x[c.slot] = c.pos[0];
      ctr_y[c.slot] = c.pos[1];
      ctr_z[c.slot] = c.pos[2];
      rad_mem[c.slot] = c.radius;
      mat_mem[c.slot] = c.mat;
    end else begin
      pending_hits.push_back(closest_hit(c));
    end
  endtask

  // Stop sending and wait until every trace has reported, plus a margin for
  // a load that may still be finishing.
  task automatic drain;
    start_i <= 1'b0;
    burst_left = 0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input crsh_pkg::cfg_reg_e idx, input logic [30:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      crsh_pkg::CFG_COUNT: sphere_cnt = val[6:0];
      crsh_pkg::CFG_TMIN:  tmin_reg = val;
      default:             tmax_reg = val;
    endcase
  endtask

  function automatic ray_cmd_t make_cmd(input crsh_pkg::cmd_e cmd, input logic [5:0] slot,
                                        input longint px, input longint py, input longint pz,
                                        input longint dx, input longint dy, input longint dz,
                                        input logic [30:0] radius, input logic [7:0] mat);
    ray_cmd_t c;
    c.cmd = cmd;
    c.slot = slot;
    c.pos[0] = px[31:0];
    c.pos[1] = py[31:0];
    c.pos[2] = pz[31:0];
    c.dir[0] = dx[31:0];
    c.dir[1] = dy[31:0];
    c.dir[2] = dz[31:0];
    c.radius = radius;
    c.mat = mat;
    return c;
  endfunction

  function automatic longint rnd_span(input int units);
    return longint'($urandom_range(0, 2 * units * ONE)) - units * ONE;
  endfunction

  // After reset the count is zero, so a trace misses without touching memory.
  task automatic test_reset_state;
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 0, 0, 0, 0, 0, ONE, 0, 0));
  endtask

  // Hand-built scene: a unit-scale sphere ahead on z, a zero-radius sphere,
  // a huge sphere around the origin and two at opposite corners of the space.
  task automatic test_directed_geometry;
    send_cmd(make_cmd(crsh_pkg::CMD_LOAD, 0, 0, 0, 10 * ONE, 0, 0, 0, 2 * ONE, 8'hFF));
    send_cmd(make_cmd(crsh_pkg::CMD_LOAD, 1, 0, 0, 20 * ONE, 0, 0, 0, 0, 8'h00));
    send_cmd(make_cmd(crsh_pkg::CMD_LOAD, 2, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF, 8'h5A));
    send_cmd(make_cmd(crsh_pkg::CMD_LOAD, 3, -64'sd2147483648, 64'sd2147483647,
                      -64'sd2147483648, 0, 0, 0, 31'd1, 8'hA5));
    send_cmd(make_cmd(crsh_pkg::CMD_LOAD, 63, 64'sd2147483647, -64'sd2147483648,
                      64'sd2147483647, 0, 0, 0, 31'd1, 8'h3C));
    drain();
    write_reg(crsh_pkg::CFG_COUNT, 2);
    // Straight hit, then a ray pointing away, then a grazing (tangent) ray.
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 0, 0, 0, 0, 0, ONE, 0, 0));
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 0, 0, 0, 0, 0, -ONE, 0, 0));
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 2 * ONE, 0, 0, 0, 0, ONE, 0, 0));
    // Origin inside the sphere takes the far root.
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 0, ONE, 10 * ONE, ONE, 0, ONE, 0, 0));
    // Direction so short that its squared length floors to zero.
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    drain();
    write_reg(crsh_pkg::CFG_COUNT, 4);
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 64'sd2147483647, 64'sd2147483647,
                      64'sd2147483647, -64'sd2147483648, -64'sd2147483648,
                      -64'sd2147483648, 0, 0));
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, -64'sd2147483648, -64'sd2147483648,
                      -64'sd2147483648, 64'sd2147483647, 64'sd2147483647,
                      64'sd2147483647, 0, 0));
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 0, 0, -3 * ONE, 0, ONE / 2, ONE, 0, 0));
  endtask

  // Distance window extremes, including an empty window.
  task automatic test_bounds;
    drain();
    write_reg(crsh_pkg::CFG_TMIN, 31'h7FFFFFFF);
    write_reg(crsh_pkg::CFG_TMAX, 0);
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 0, 0, 0, 0, 0, ONE, 0, 0));
    drain();
    write_reg(crsh_pkg::CFG_TMIN, 100 * ONE);
    write_reg(crsh_pkg::CFG_TMAX, 5 * ONE);
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 0, 0, 0, 0, 0, ONE, 0, 0));
    drain();
    write_reg(crsh_pkg::CFG_TMIN, 0);
    write_reg(crsh_pkg::CFG_TMAX, 31'h7FFFFFFF);
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 0, 0, 0, 0, 0, ONE, 0, 0));
    send_cmd(make_cmd(crsh_pkg::CMD_TRACE, 0, 0, 0, 8 * ONE, 0, 0, ONE, 0, 0));
  endtask

  function automatic ray_cmd_t rand_load(input bit noise);
    ray_cmd_t c;
    c.cmd = crsh_pkg::CMD_LOAD;
    c.slot = $urandom_range(0, 63);
    for (int j = 0; j < 3; j++) begin
      c.pos[j] = noise ? $urandom : rnd_span(8);
      c.dir[j] = $urandom;
    end
    c.radius = noise ? 31'($urandom) : 31'(ONE / 2 + $urandom_range(0, 3 * ONE));
    c.mat = $urandom;
    return c;
  endfunction

  // A ray aimed at one of the tested spheres, with jitter so that some
  // miss, some graze and some start inside. Now and then it points away.
  function automatic ray_cmd_t rand_trace(input bit noise);
    ray_cmd_t c;
    longint tgt [3];
    longint dv;
    int n, k, shr;
    c.cmd = crsh_pkg::CMD_TRACE;
    c.slot = $urandom;
    c.radius = $urandom;
    c.mat = $urandom;
    n = sphere_cnt > 64 ? 64 : sphere_cnt;
    k = n > 0 ? $urandom_range(0, n - 1) : 0;
    tgt[0] = n > 0 ? longint'(ctr_x[k]) : rnd_span(8);
    tgt[1] = n > 0 ? longint'(ctr_y[k]) : rnd_span(8);
    tgt[2] = n > 0 ? longint'(ctr_z[k]) : rnd_span(8);
    shr = $urandom_range(0, 3);
    for (int j = 0; j < 3; j++) begin
      c.pos[j] = noise ? $urandom : rnd_span(16);
      dv = ((tgt[j] - longint'(c.pos[j])) + rnd_span(1)) >>> shr;
      if ($urandom_range(0, 9) == 0) dv = -dv;
      c.dir[j] = noise ? $urandom : clip(dv, -64'sd2147483648, 64'sd2147483647);
    end
    return c;
  endfunction

  // Random phases with changing configuration. Before the first phase the
  // whole memory is filled, so any count is legal from then on.
  task automatic test_random_phases;
    int sel;
    logic [30:0] cnt, tmin, tmax;
    drain();
    for (int s = 0; s < 64; s++) begin
      send_cmd(make_cmd(crsh_pkg::CMD_LOAD, s[5:0], rnd_span(8), rnd_span(8), rnd_span(8),
                        0, 0, 0, 31'(ONE / 2 + $urandom_range(0, 3 * ONE)), $urandom));
    end
    for (int p = 0; p < PHASES; p++) begin
      drain();
      sel = $urandom_range(0, 9);
      cnt = sel == 0 ? 31'd0 : (sel == 1 ? 31'd64 :
            (sel == 2 ? 31'd127 : 31'($urandom_range(1, 6))));
      sel = $urandom_range(0, 5);
      tmin = sel < 3 ? 31'd66 : (sel == 3 ? 31'd0 : 31'($urandom_range(0, 4 * ONE)));
      sel = $urandom_range(0, 5);
      tmax = sel < 3 ? 31'h7FFFFFFF :
             (sel == 3 ? 31'd0 : 31'($urandom_range(ONE, 40 * ONE)));
      // Force counts 127 and 64, both TMIN extremes and the largest TMAX early on.
      if (p == 1) begin
        cnt = 127;
        tmin = 0;
        tmax = 31'h7FFFFFFF;
      end else if (p == 2) begin
        cnt = 64;
      end else if (p == 3) begin
        tmin = 31'h7FFFFFFF;
      end
      write_reg(crsh_pkg::CFG_COUNT, cnt);
      write_reg(crsh_pkg::CFG_TMIN, tmin);
      write_reg(crsh_pkg::CFG_TMAX, tmax);
      for (int i = 0; i < PHASE_N; i++) begin
        sel = $urandom_range(0, 19);
        if (sel < 2) send_cmd(rand_load(0));
        else if (sel < 3) send_cmd(rand_load(1));
        else if (sel < 17) send_cmd(rand_trace(0));
        else send_cmd(rand_trace(1));
      end
    end
  endtask

  initial begin
    err_cnt = 0;
    burst_left = 0;
    sphere_cnt = 0;
    tmin_reg = 66;
    tmax_reg = 31'h7FFFFFFF;
    for (int s = 0; s < 64; s++) begin
      ctr_x[s] = 0;
      ctr_y[s] = 0;
      ctr_z[s] = 0;
      rad_mem[s] = 0;
      mat_mem[s] = 0;
    end
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    command_i     <= 1'b0;
    slot_i        <= '0;
    pos_x_i       <= '0;
    pos_y_i       <= '0;
    pos_z_i       <= '0;
    dir_x_i       <= '0;
    dir_y_i       <= '0;
    dir_z_i       <= '0;
    radius_i      <= '0;
    material_id_i <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_geometry();
    test_bounds();
    test_random_phases();

    drain();
    repeat (50) @(posedge clk_i);
    if (pending_hits.size() != 0) report_mismatch("results never seen", 0, pending_hits.size());
    if (err_cnt == 0) begin
      $display("closest_ray_sphere_hit_top verification clean");
    end else begin
      $display("closest_ray_sphere_hit_top verification failed");
    end
    $finish;
  end

endmodule

[closest_ray_sphere_hit_top.f]
design/crsh_pkg.sv
design/closest_ray_sphere_hit_top.sv
tb/sv/closest_ray_sphere_hit_top_tb.sv
